/* hdl/pnn_pkg.sv */
// Shared types and constants for the Newell polygon normal block.
`timescale 1ns / 1ps
package pnn_pkg;
	localparam int ACC_W = 48;
	localparam int OUT_W = 16;
	localparam int MAG_W = 30;
	localparam int SQ_W  = 62;
	localparam int LEN_W = 31;
	localparam int QUO_W = 15;
	localparam int FRAC  = 14;
	localparam logic [QUO_W-1:0] UNIT_Q14 = 15'd16384;

	typedef struct packed {
		logic signed [ACC_W-1:0] sx;
		logic signed [ACC_W-1:0] sy;
		logic signed [ACC_W-1:0] sz;
	} sums_t;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_ADD  = 4'b0100,
		F_PUSH = 4'b1000
	} front_st_t;

	typedef enum logic [6:0] {
		B_IDLE  = 7'b0000001,
		B_SHIFT = 7'b0000010,
		B_SQ    = 7'b0000100,
		B_ROOT  = 7'b0001000,
		B_DLOAD = 7'b0010000,
		B_DIV   = 7'b0100000,
		B_OUT   = 7'b1000000
	} back_st_t;
endpackage

/* hdl/pnn_front.sv */
// Vertex intake and Newell edge accumulation.
`timescale 1ns / 1ps
module pnn_front import pnn_pkg::*; #(
	parameter int CW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [CW-1:0] vertex_x,
	input  logic signed [CW-1:0] vertex_y,
	input  logic signed [CW-1:0] vertex_z,
	input  logic                 last_vertex,
	output logic                 push,
	output sums_t                push_data,
	input  logic                 q_full
);
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int EXT = ((PW > ACC_W) ? PW : ACC_W) + 1;
	localparam logic signed [EXT-1:0] ACC_HI = EXT'({1'b0, {(ACC_W-1){1'b1}}});
	localparam logic signed [EXT-1:0] ACC_LO = -ACC_HI - EXT'(1);

	front_st_t st_q;
	logic in_poly_q, close_q, last_q;
	logic signed [CW-1:0] fx_q, fy_q, fz_q, px_q, py_q, pz_q;
	logic signed [CW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [PW-1:0] prx_q, pry_q, prz_q;
	logic signed [ACC_W-1:0] sx_q, sy_q, sz_q;
	logic signed [ACC_W-1:0] sx_n, sy_n, sz_n;

	function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] acc,
			logic signed [PW-1:0] p);
		logic signed [EXT-1:0] r;
		r = EXT'(acc) + EXT'(p);
		if (r > ACC_HI) return ACC_HI[ACC_W-1:0];
		else if (r < ACC_LO) return ACC_LO[ACC_W-1:0];
		else return r[ACC_W-1:0];
	endfunction

	assign sx_n = sat_add(sx_q, prx_q);
	assign sy_n = sat_add(sy_q, pry_q);
	assign sz_n = sat_add(sz_q, prz_q);

	assign in_stall = (st_q != F_IDLE);
	assign push = (st_q == F_PUSH) && !q_full;
	assign push_data = '{sx: sx_q, sy: sy_q, sz: sz_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			in_poly_q <= 1'b0;
			close_q <= 1'b0;
			last_q <= 1'b0;
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (in_valid) begin
						px_q <= vertex_x;
						py_q <= vertex_y;
						pz_q <= vertex_z;
						if (!in_poly_q) begin
							fx_q <= vertex_x;
							fy_q <= vertex_y;
							fz_q <= vertex_z;
							in_poly_q <= 1'b1;
							if (last_vertex) st_q <= F_PUSH;
						end else begin
							ax_q <= px_q;
							ay_q <= py_q;
							az_q <= pz_q;
							bx_q <= vertex_x;
							by_q <= vertex_y;
							bz_q <= vertex_z;
							close_q <= last_vertex;
							last_q <= last_vertex;
							st_q <= F_MUL;
						end
					end
				end
				F_MUL: st_q <= F_ADD;
				F_ADD: begin
					sx_q <= sx_n;
					sy_q <= sy_n;
					sz_q <= sz_n;
					if (close_q) begin
						ax_q <= px_q;
						ay_q <= py_q;
						az_q <= pz_q;
						bx_q <= fx_q;
						by_q <= fy_q;
						bz_q <= fz_q;
						close_q <= 1'b0;
						st_q <= F_MUL;
					end else if (last_q) begin
						st_q <= F_PUSH;
					end else begin
						st_q <= F_IDLE;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						sx_q <= '0;
						sy_q <= '0;
						sz_q <= '0;
						in_poly_q <= 1'b0;
						last_q <= 1'b0;
						st_q <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	// edge products, one register stage
	always_ff @(posedge clk) begin
		if (st_q == F_MUL) begin
			prx_q <= (DW'(ay_q) - DW'(by_q)) * (DW'(az_q) + DW'(bz_q));
			pry_q <= (DW'(az_q) - DW'(bz_q)) * (DW'(ax_q) + DW'(bx_q));
			prz_q <= (DW'(ax_q) - DW'(bx_q)) * (DW'(ay_q) + DW'(by_q));
		end
	end
endmodule

/* hdl/pnn_queue.sv */
// Two-entry queue of accumulated sums between front and back.
`timescale 1ns / 1ps
module pnn_queue import pnn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  sums_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output sums_t pop_data
);
	sums_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* hdl/pnn_back.sv */
// Normalization: range shift, squares, bit-serial root and division, result register.
`timescale 1ns / 1ps
module pnn_back import pnn_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  sums_t                   q_data,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] normal_x,
	output logic signed [OUT_W-1:0] normal_y,
	output logic signed [OUT_W-1:0] normal_z,
	output logic                    degenerate
);
	back_st_t st_q;
	logic [ACC_W-1:0] ax_q, ay_q, az_q;
	logic [2:0] sgn_q;
	logic [1:0] cnt_q;
	logic [SQ_W-1:0] sq_q, rx_q;
	logic [SQ_W:0] res_q;
	logic [4:0] k_q;
	logic [LEN_W-1:0] len_q;
	logic [45:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0] i_q;
	logic [OUT_W-1:0] nx_q, ny_q, nz_q;
	logic degen_q, out_valid_q;
	logic [OUT_W-1:0] ox_q, oy_q, oz_q;
	logic odeg_q;

	logic [MAG_W-1:0] sel_a;
	logic sel_s;
	logic [SQ_W-1:0] sq_sum;
	logic [SQ_W:0] bitv, trial, res_nxt;
	logic ge;
	logic [45:0] dtrial;
	logic dge;
	logic [QUO_W-1:0] quo_nxt, quo_cap;
	logic [OUT_W-1:0] comp;
	logic big;

	function automatic logic [ACC_W-1:0] mag(logic signed [ACC_W-1:0] s);
		return s[ACC_W-1] ? (~s + ACC_W'(1)) : s;
	endfunction

	always_comb begin
		unique case (cnt_q)
			2'd0: begin sel_a = ax_q[MAG_W-1:0]; sel_s = sgn_q[0]; end
			2'd1: begin sel_a = ay_q[MAG_W-1:0]; sel_s = sgn_q[1]; end
			default: begin sel_a = az_q[MAG_W-1:0]; sel_s = sgn_q[2]; end
		endcase
	end

	assign big = (ax_q[ACC_W-1:MAG_W] != '0) || (ay_q[ACC_W-1:MAG_W] != '0) ||
		(az_q[ACC_W-1:MAG_W] != '0);
	assign sq_sum = sq_q + SQ_W'(sel_a) * SQ_W'(sel_a);

	assign bitv = (SQ_W+1)'(1) << {k_q, 1'b0};
	assign trial = res_q + bitv;
	assign ge = ({1'b0, rx_q} >= trial);
	assign res_nxt = ge ? ((res_q >> 1) + bitv) : (res_q >> 1);

	assign dtrial = 46'(len_q) << i_q;
	assign dge = (rem_q >= dtrial);
	always_comb begin
		quo_nxt = quo_q;
		if (dge) quo_nxt = quo_q | (QUO_W'(1) << i_q);
	end
	assign quo_cap = (quo_nxt > UNIT_Q14) ? UNIT_Q14 : quo_nxt;
	assign comp = sel_s ? (OUT_W'(0) - OUT_W'(quo_cap)) : OUT_W'(quo_cap);

	assign pop = (st_q == B_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign normal_x = ox_q;
	assign normal_y = oy_q;
	assign normal_z = oz_q;
	assign degenerate = odeg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((st_q == B_OUT) && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (st_q)
				B_IDLE: if (q_valid) st_q <= B_SHIFT;
				B_SHIFT: if (!big) st_q <= B_SQ;
				B_SQ: if (cnt_q == 2'd2) st_q <= B_ROOT;
				B_ROOT: begin
					if (k_q == '0) st_q <= (res_nxt == '0) ? B_OUT : B_DLOAD;
				end
				B_DLOAD: st_q <= B_DIV;
				B_DIV: begin
					if (i_q == '0) st_q <= (cnt_q == 2'd2) ? B_OUT : B_DLOAD;
				end
				B_OUT: begin
					if (!out_valid_q || !out_stall) st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				ax_q <= mag(q_data.sx);
				ay_q <= mag(q_data.sy);
				az_q <= mag(q_data.sz);
				sgn_q <= {q_data.sz[ACC_W-1], q_data.sy[ACC_W-1], q_data.sx[ACC_W-1]};
			end
			B_SHIFT: begin
				if (big) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
					az_q <= az_q >> 1;
				end else begin
					cnt_q <= '0;
					sq_q <= '0;
				end
			end
			B_SQ: begin
				sq_q <= sq_sum;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					rx_q <= sq_sum;
					res_q <= '0;
					k_q <= 5'd31;
				end
			end
			B_ROOT: begin
				if (ge) rx_q <= rx_q - trial[SQ_W-1:0];
				res_q <= res_nxt;
				k_q <= k_q - 5'd1;
				if (k_q == '0) begin
					len_q <= res_nxt[LEN_W-1:0];
					cnt_q <= '0;
					degen_q <= (res_nxt == '0);
					nx_q <= '0;
					ny_q <= '0;
					nz_q <= '0;
				end
			end
			B_DLOAD: begin
				rem_q <= 46'({sel_a, {FRAC{1'b0}}}) + 46'(len_q >> 1);
				quo_q <= '0;
				i_q <= 4'(QUO_W - 1);
			end
			B_DIV: begin
				if (dge) rem_q <= rem_q - dtrial;
				quo_q <= quo_nxt;
				i_q <= i_q - 4'd1;
				if (i_q == '0) begin
					unique case (cnt_q)
						2'd0: nx_q <= comp;
						2'd1: ny_q <= comp;
						default: nz_q <= comp;
					endcase
					cnt_q <= cnt_q + 2'd1;
				end
			end
			B_OUT: begin
				if (!out_valid_q || !out_stall) begin
					ox_q <= nx_q;
					oy_q <= ny_q;
					oz_q <= nz_q;
					odeg_q <= degen_q;
				end
			end
			default: ;
		endcase
	end
endmodule

/* hdl/polygon_normal_newell_top.sv */
// Top level of the Newell polygon normal block.
// A vertex is taken only while the front is idle; after each vertex but the first
// of a polygon the input stalls while the edge multiply and saturating accumulate
// (one stage each) run. The last vertex adds the closing edge and the hand-off of
// the sums to a two-entry queue, and the input stalls on while the queue is full.
// Normalization runs per polygon behind the queue in up to 18 shift steps,
// 3 squares, a 32-step bit-serial square root and three bit-serial
// divisions; a zero-length sum skips the divisions. It overlaps
// accumulation of the following polygons. The result is held in an
// output register until taken.
`timescale 1ns / 1ps
module polygon_normal_newell_top import pnn_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_z,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_W-1:0]       normal_x,
	output logic signed [OUT_W-1:0]       normal_y,
	output logic signed [OUT_W-1:0]       normal_z,
	output logic                          degenerate
);
	logic push, q_full, pop, q_valid;
	sums_t push_data, pop_data;

	pnn_front #(.CW(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.last_vertex(last_vertex),
		.push(push), .push_data(push_data), .q_full(q_full)
	);

	pnn_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(q_full),
		.pop(pop), .not_empty(q_valid), .pop_data(pop_data)
	);

	pnn_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_data(pop_data), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);
endmodule

/* bench/polygon_normal_newell_top_tb.sv */
// Self-checking testbench for the Newell polygon normal block: directed table plus random polygons.
`timescale 1ns / 1ps
module polygon_normal_newell_top_tb import pnn_pkg::*;;

	localparam int CW = 16;
	localparam int WATCHDOG = 20000;
	localparam logic [47:0] ACC_MAXV = 48'h7FFF_FFFF_FFFF;

	typedef struct {
		logic signed [CW-1:0] x, y, z;
		logic                 last;
	} vin_t;

	typedef struct {
		logic signed [OUT_W-1:0] nx, ny, nz;
		logic                    degen;
	} normal_t;

	typedef struct {
		vin_t    v;
		bit      has_exp;
		normal_t exp;
	} row_t;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall;
	logic signed [CW-1:0] vertex_x, vertex_y, vertex_z;
	logic                 last_vertex;
	logic                 out_valid, out_stall;
	logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
	logic                 degenerate;

	polygon_normal_newell_top #(.COORD_WIDTH(CW)) dut (.*);

	// predictor state
	logic signed [63:0] first_x, first_y, first_z, prev_x, prev_y, prev_z;
	logic signed [63:0] acc_x, acc_y, acc_z;
	bit open_poly;
	normal_t normals_due[$];
	int errors, idle_cycles, in_idle_pct, out_stall_pct;
	bit done;

	function automatic logic signed [63:0] sat48(logic signed [63:0] a, logic signed [63:0] p);
		logic signed [63:0] r;
		r = a + p;
		if (r > $signed({16'd0, ACC_MAXV})) return $signed({16'd0, ACC_MAXV});
		if (r < -$signed({16'd0, ACC_MAXV}) - 1) return -$signed({16'd0, ACC_MAXV}) - 1;
		return r;
	endfunction

	task automatic add_edge(logic signed [63:0] px, py, pz, qx, qy, qz);
		acc_x = sat48(acc_x, (py - qy) * (pz + qz));
		acc_y = sat48(acc_y, (pz - qz) * (px + qx));
		acc_z = sat48(acc_z, (px - qx) * (py + qy));
	endtask

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [OUT_W-1:0] unit_comp(logic signed [63:0] s, logic [63:0] a,
			logic [63:0] len);
		logic [63:0] q;
		q = (a * 16384 + len / 2) / len;
		if (q > 16384) q = 16384;
		if (s < 0) q = -q;
		return q[15:0];
	endfunction

	function automatic normal_t newell_normal();
		normal_t n;
		logic [63:0] ax, ay, az, m, len;
		int sh;
		ax = acc_x < 0 ? -acc_x : acc_x;
		ay = acc_y < 0 ? -acc_y : acc_y;
		az = acc_z < 0 ? -acc_z : acc_z;
		m = ax;
		if (ay > m) m = ay;
		if (az > m) m = az;
		sh = 0;
		while ((m >> sh) >= (64'd1 << 30)) sh++;
		ax >>= sh; ay >>= sh; az >>= sh;
		len = isqrt(ax * ax + ay * ay + az * az);
		if (len == 0) begin
			n = '{0, 0, 0, 1'b1};
		end else begin
			n.nx = unit_comp(acc_x, ax, len);
			n.ny = unit_comp(acc_y, ay, len);
			n.nz = unit_comp(acc_z, az, len);
			n.degen = 1'b0;
		end
		return n;
	endfunction

	task automatic predict_vertex(vin_t v);
		if (!open_poly) begin
			first_x = v.x; first_y = v.y; first_z = v.z;
			acc_x = 0; acc_y = 0; acc_z = 0;
			open_poly = 1;
		end else
			add_edge(prev_x, prev_y, prev_z, v.x, v.y, v.z);
		prev_x = v.x; prev_y = v.y; prev_z = v.z;
		if (v.last) begin
			add_edge(v.x, v.y, v.z, first_x, first_y, first_z);
			normals_due.push_back(newell_normal());
			acc_x = 0; acc_y = 0; acc_z = 0;
			open_poly = 0;
		end
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver side
	always @(posedge clk) begin
		normal_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (normals_due.size() == 0) begin
				$error("normal with none expected");
				errors++;
			end else begin
				e = normals_due.pop_front();
				if (normal_x !== e.nx) begin
					$error("normal_x exp %0d got %0d", e.nx, normal_x); errors++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y exp %0d got %0d", e.ny, normal_y); errors++;
				end
				if (normal_z !== e.nz) begin
					$error("normal_z exp %0d got %0d", e.nz, normal_z); errors++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate exp %0b got %0b", e.degen, degenerate); errors++;
				end
			end
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < out_stall_pct);

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !done) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_vertex(vin_t v);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		vertex_x <= v.x; vertex_y <= v.y; vertex_z <= v.z; last_vertex <= v.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_vertex(v);
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rnd_coord();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return CW'(int'($urandom_range(31)) - 16);
			default: return $signed(CW'($urandom));
		endcase
	endfunction

	task automatic random_polygon(output int nv);
		int n;
		vin_t v, p;
		n = ($urandom_range(19) == 0) ? $urandom_range(40, 128) : $urandom_range(1, 8);
		p = '{rnd_coord(), rnd_coord(), rnd_coord(), 1'b0};
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: v = p;
				1: v = '{p.x, p.y, rnd_coord(), 1'b0};
				default: v = '{rnd_coord(), rnd_coord(), rnd_coord(), 1'b0};
			endcase
			v.last = (i == n - 1);
			send_vertex(v);
			p = v;
		end
		nv = n;
	endtask

	row_t directed[$];
	int sent, nv;

	initial begin
		done = 0; open_poly = 0;
		in_idle_pct = 0; out_stall_pct = 0;
		acc_x = 0; acc_y = 0; acc_z = 0;
		in_valid = 0; arst_n = 0;
		vertex_x = 0; vertex_y = 0; vertex_z = 0; last_vertex = 0;
		directed = '{
			'{'{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1, '{0, 0, 0, 1'b1}},
			'{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1}, 1, '{0, 0, 0, 1'b1}},
			'{'{16'sd0, 16'sd0, 16'sd0, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sd256, 16'sd0, 16'sd0, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sd0, 16'sd256, 16'sd0, 1'b1}, 1, '{0, 0, 16'sd16384, 1'b0}},
			'{'{16'sd0, 16'sd0, 16'sd0, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sd0, 16'sd256, 16'sd0, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sd256, 16'sd0, 16'sd0, 1'b1}, 1, '{0, 0, -16'sd16384, 1'b0}},
			'{'{16'sd5, 16'sd5, 16'sd5, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sd5, 16'sd5, 16'sd5, 1'b1}, 1, '{0, 0, 0, 1'b1}},
			'{'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1}, 0, '{0, 0, 0, 0}},
			'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{-16'sd1, 16'sd0, 16'sh8000, 1'b0}, 0, '{0, 0, 0, 0}},
			'{'{16'sd0, -16'sd1, 16'sd1, 1'b1}, 0, '{0, 0, 0, 0}}
		};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		foreach (directed[i]) begin
			send_vertex(directed[i].v);
			if (directed[i].has_exp) normals_due[normals_due.size() - 1] = directed[i].exp;
		end
		sent = directed.size();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 53; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 53; end
				3: begin in_idle_pct = 28; out_stall_pct = 28; end
				default: begin in_idle_pct = 0; out_stall_pct = 0; end
			endcase
			while (sent < 330 * (ph + 1)) begin
				random_polygon(nv);
				sent = sent + nv;
			end
			// drain before next phase
			in_valid <= 0;
			while (normals_due.size() != 0) @(negedge clk);
		end
		out_stall_pct = 0;
		while (normals_due.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		done = 1;
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
